### sv/assert_macros.svh
// assertion helpers used by spq_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/spq_pkg.sv
package spq_pkg;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_CHANGE  = 2'd2,
        FUNC_REMOVE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLAG,
        S_SWEEP,
        S_APPLY
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [15:0]        tag;
        logic signed [31:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        out_tag;
        logic signed [31:0] out_priority;
        t_status            status;
        logic [4:0]         occupancy;
    } t_out_item;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               load;
        logic               sweep;
        logic               apply;
        t_func              func;
        logic signed [31:0] key;
    } t_cell_ctrl;

endpackage

### sv/spq_cell.sv
module spq_cell #(
    parameter int TW  = 16,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  spq_pkg::t_cell_ctrl  i_ctrl,
    input  logic [TW-1:0]        i_tag,
    input  logic [CW-1:0]        i_count,
    input  logic signed [31:0]   i_left_key,
    input  logic [TW-1:0]        i_left_tag,
    input  logic                 i_left_le,
    input  logic                 i_left_seen,
    input  logic                 i_left_down,
    input  logic signed [31:0]   i_right_key,
    input  logic [TW-1:0]        i_right_tag,
    input  logic                 i_right_lt,
    input  logic                 i_right_up,
    output logic signed [31:0]   o_key,
    output logic [TW-1:0]        o_tag,
    output logic                 o_le,
    output logic                 o_lt,
    output logic                 o_seen,
    output logic                 o_down,
    output logic                 o_up
);

    typedef enum logic [1:0] {
        PICK_KEEP,
        PICK_LEFT,
        PICK_RIGHT,
        PICK_NEW
    } t_pick;

    logic signed [31:0] r_key;
    logic [TW-1:0]      r_tag;
    logic               r_le;
    logic               r_lt;
    logic               r_tm;
    logic               r_seen;
    logic               r_down;
    logic               r_up;

    logic  w_valid;
    logic  w_up_cond;
    t_pick w_pick;

    assign w_valid   = (CW'(IDX) < i_count);
    // the removed entry would move toward the head: its left neighbor is above the new key
    assign w_up_cond = !i_left_le;

    always_comb begin
        w_pick = PICK_KEEP;
        unique case (i_ctrl.func)
            spq_pkg::FUNC_INSERT: begin
                w_pick = r_le ? PICK_KEEP : (i_left_le ? PICK_NEW : PICK_LEFT);
            end
            spq_pkg::FUNC_EXTRACT: begin
                w_pick = PICK_RIGHT;
            end
            spq_pkg::FUNC_REMOVE: begin
                w_pick = (i_left_seen || r_tm) ? PICK_RIGHT : PICK_KEEP;
            end
            spq_pkg::FUNC_CHANGE: begin
                priority if (i_left_seen) begin
                    // behind the matched entry: only the toward-tail move touches us
                    if (i_left_down) begin
                        w_pick = i_right_lt ? PICK_RIGHT : (r_lt ? PICK_NEW : PICK_KEEP);
                    end
                end else if (r_tm) begin
                    w_pick = w_up_cond ? PICK_LEFT : (i_right_lt ? PICK_RIGHT : PICK_NEW);
                end else if (i_right_up) begin
                    w_pick = r_le ? PICK_KEEP : (i_left_le ? PICK_NEW : PICK_LEFT);
                end else begin
                    w_pick = PICK_KEEP;
                end
            end
            default: w_pick = PICK_KEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_le <= w_valid && !(i_ctrl.key < r_key);
            r_lt <= w_valid && (r_key < i_ctrl.key);
            r_tm <= w_valid && (r_tag == i_tag);
        end
        if (i_ctrl.sweep) begin
            r_seen <= i_left_seen || r_tm;
            r_down <= i_left_seen ? i_left_down : (r_tm && i_right_lt);
            r_up   <= r_tm ? w_up_cond : i_right_up;
        end
        if (i_ctrl.apply) begin
            unique case (w_pick)
                PICK_KEEP: begin
                    r_key <= r_key;
                    r_tag <= r_tag;
                end
                PICK_LEFT: begin
                    r_key <= i_left_key;
                    r_tag <= i_left_tag;
                end
                PICK_RIGHT: begin
                    r_key <= i_right_key;
                    r_tag <= i_right_tag;
                end
                PICK_NEW: begin
                    r_key <= i_ctrl.key;
                    r_tag <= i_tag;
                end
                default: begin
                    r_key <= r_key;
                    r_tag <= r_tag;
                end
            endcase
        end
    end

    assign o_key  = r_key;
    assign o_tag  = r_tag;
    assign o_le   = r_le;
    assign o_lt   = r_lt;
    assign o_seen = r_seen;
    assign o_down = r_down;
    assign o_up   = r_up;

endmodule

### sv/spq_ctrl.sv
`include "assert_macros.svh"

module spq_ctrl #(
    parameter int CAPACITY = 16,
    parameter int TW       = 16,
    parameter int CW       = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spq_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spq_pkg::t_out_item   o_out,
    input  logic                 i_found,
    input  logic signed [31:0]   i_head_key,
    input  logic [TW-1:0]        i_head_tag,
    output spq_pkg::t_cell_ctrl  o_ctrl,
    output logic [TW-1:0]        o_tag,
    output logic [CW-1:0]        o_count
);

    localparam int NW = $clog2(CAPACITY);

    spq_pkg::t_state    r_state;
    spq_pkg::t_state    n_state;
    spq_pkg::t_in_item  r_op;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [NW-1:0]      r_cnt;
    spq_pkg::t_out_item r_out;
    spq_pkg::t_out_item n_out;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_apply_go;
    logic               w_ok;
    spq_pkg::t_status   w_status;
    logic [CW+4:0]      w_occ_ext;

    assign w_accept   = i_in_valid && (r_state == spq_pkg::S_IDLE);
    assign w_apply_go = (r_state == spq_pkg::S_APPLY) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = spq_pkg::S_FLAG;
                end
            end
            spq_pkg::S_FLAG: begin
                if (r_op.func == spq_pkg::FUNC_CHANGE || r_op.func == spq_pkg::FUNC_REMOVE) begin
                    n_state = spq_pkg::S_SWEEP;
                end else begin
                    n_state = spq_pkg::S_APPLY;
                end
            end
            spq_pkg::S_SWEEP: begin
                if (r_cnt == NW'(CAPACITY - 1)) begin
                    n_state = spq_pkg::S_APPLY;
                end
            end
            spq_pkg::S_APPLY: begin
                if (w_apply_go) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    // outcome of the operation held in r_op
    always_comb begin
        w_ok     = 1'b0;
        w_status = spq_pkg::ST_OK;
        n_count  = r_count;
        unique case (r_op.func)
            spq_pkg::FUNC_INSERT: begin
                w_ok     = (r_count < CW'(CAPACITY));
                w_status = w_ok ? spq_pkg::ST_OK : spq_pkg::ST_FULL;
                n_count  = w_ok ? r_count + CW'(1) : r_count;
            end
            spq_pkg::FUNC_EXTRACT: begin
                w_ok     = (r_count != '0);
                w_status = w_ok ? spq_pkg::ST_OK : spq_pkg::ST_EMPTY;
                n_count  = w_ok ? r_count - CW'(1) : r_count;
            end
            spq_pkg::FUNC_REMOVE: begin
                w_ok     = i_found;
                w_status = w_ok ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
                n_count  = w_ok ? r_count - CW'(1) : r_count;
            end
            spq_pkg::FUNC_CHANGE: begin
                w_ok     = i_found;
                w_status = w_ok ? spq_pkg::ST_OK : spq_pkg::ST_NOT_FOUND;
            end
            default: w_ok = 1'b0;
        endcase
    end

    assign w_occ_ext = {5'd0, n_count};

    always_comb begin
        n_out.out_tag      = '0;
        n_out.out_priority = '0;
        if (r_op.func == spq_pkg::FUNC_EXTRACT && w_ok) begin
            n_out.out_tag      = 16'(i_head_tag);
            n_out.out_priority = i_head_key;
        end
        n_out.status    = w_status;
        n_out.occupancy = w_occ_ext[4:0];
    end

    // outputs
    always_comb begin
        o_in_stall   = (r_state != spq_pkg::S_IDLE);
        o_ctrl.load  = (r_state == spq_pkg::S_FLAG);
        o_ctrl.sweep = (r_state == spq_pkg::S_SWEEP);
        o_ctrl.apply = w_apply_go && w_ok;
        o_ctrl.func  = r_op.func;
        o_ctrl.key   = r_op.priority_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == spq_pkg::S_FLAG) begin
                r_cnt <= '0;
            end else if (r_state == spq_pkg::S_SWEEP) begin
                r_cnt <= r_cnt + NW'(1);
            end
            if (w_apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in;
        end
        if (w_apply_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_tag       = r_op.tag[TW-1:0];
    assign o_count     = r_count;

    `ASSERT_ALWAYS(a_count_range, r_count <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_fail_keeps_count, w_apply_go && !w_ok, r_count == $past(r_count),
                 "failed operation changed the entry count")
    `ASSERT_NEXT(a_extract_dec, w_apply_go && w_ok && r_op.func == spq_pkg::FUNC_EXTRACT,
                 r_count == $past(r_count) - CW'(1), "extract did not shrink the queue")

endmodule

### sv/sorted_priority_queue.sv
// insert and extract pass through FLAG and then APPLY, which registers the result;
// change-key and remove pass through FLAG, SWEEP and APPLY (match token ripples one
// cell a cycle); a new item is taken only in IDLE, and APPLY waits on a stalled result;
// the result register lets the next item in while that result waits;
// reset (synchronous, active low) empties the queue and drops any pending result;
// cell contents are left as they are
module sorted_priority_queue #(
    parameter int CAPACITY  = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spq_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spq_pkg::t_out_item  o_out
);

    localparam int TW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::t_cell_ctrl w_ctrl;
    logic [TW-1:0]       w_tag;
    logic [CW-1:0]       w_count;

    logic signed [31:0]  w_key  [CAPACITY];
    logic [TW-1:0]       w_ctag [CAPACITY];
    logic                w_le   [CAPACITY];
    logic                w_lt   [CAPACITY];
    logic                w_seen [CAPACITY];
    logic                w_down [CAPACITY];
    logic                w_up   [CAPACITY];

    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .TW       (TW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_found     (w_seen[CAPACITY-1]),
        .i_head_key  (w_key[0]),
        .i_head_tag  (w_ctag[0]),
        .o_ctrl      (w_ctrl),
        .o_tag       (w_tag),
        .o_count     (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] l_key;
        logic [TW-1:0]      l_tag;
        logic               l_le;
        logic               l_seen;
        logic               l_down;
        logic signed [31:0] r_key;
        logic [TW-1:0]      r_tag;
        logic               r_lt;
        logic               r_up;

        // head sees a virtual neighbor below every key, tail one above every key
        if (g == 0) begin : g_head
            assign l_key  = '0;
            assign l_tag  = '0;
            assign l_le   = 1'b1;
            assign l_seen = 1'b0;
            assign l_down = 1'b0;
        end else begin : g_mid_l
            assign l_key  = w_key[g-1];
            assign l_tag  = w_ctag[g-1];
            assign l_le   = w_le[g-1];
            assign l_seen = w_seen[g-1];
            assign l_down = w_down[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign r_key = '0;
            assign r_tag = '0;
            assign r_lt  = 1'b0;
            assign r_up  = 1'b0;
        end else begin : g_mid_r
            assign r_key = w_key[g+1];
            assign r_tag = w_ctag[g+1];
            assign r_lt  = w_lt[g+1];
            assign r_up  = w_up[g+1];
        end

        spq_cell #(
            .TW  (TW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_tag       (w_tag),
            .i_count     (w_count),
            .i_left_key  (l_key),
            .i_left_tag  (l_tag),
            .i_left_le   (l_le),
            .i_left_seen (l_seen),
            .i_left_down (l_down),
            .i_right_key (r_key),
            .i_right_tag (r_tag),
            .i_right_lt  (r_lt),
            .i_right_up  (r_up),
            .o_key       (w_key[g]),
            .o_tag       (w_ctag[g]),
            .o_le        (w_le[g]),
            .o_lt        (w_lt[g]),
            .o_seen      (w_seen[g]),
            .o_down      (w_down[g]),
            .o_up        (w_up[g])
        );
    end

endmodule

### tb/sv/sorted_priority_queue_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_test;

    localparam int DEPTH          = 16;
    localparam int TAGW           = 16;
    localparam int RAND_BLOCKS    = 15;
    localparam int BLOCK_ITEMS    = 60;
    localparam int CYCLE_LIMIT    = 200000;

    // shadow copy of the sorted array, predicts one result per item
    class sorted_queue_ledger;
        logic signed [31:0]  keys [DEPTH];
        logic [15:0]         tags [DEPTH];
        int                  count;
        spq_pkg::t_out_item  awaited[$];
        int                  errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void drop(int at);
            for (int j = at; j + 1 < count; j++) begin
                keys[j] = keys[j + 1];
                tags[j] = tags[j + 1];
            end
            count--;
        endfunction

        function void place(int at, logic signed [31:0] k, logic [15:0] t);
            for (int j = count; j > at; j--) begin
                keys[j] = keys[j - 1];
                tags[j] = tags[j - 1];
            end
            keys[at] = k;
            tags[at] = t;
            count++;
        endfunction

        function void note_op(spq_pkg::t_in_item it);
            spq_pkg::t_out_item r;
            logic signed [31:0] k;
            int                 hit;
            int                 lo;
            int                 hi;
            int                 dst;
            r   = '0;
            k   = it.priority_req;
            hit = -1;
            unique case (it.func)
                spq_pkg::FUNC_INSERT: begin
                    if (count >= DEPTH) begin
                        r.status = spq_pkg::ST_FULL;
                    end else begin
                        dst = 0;
                        // equal keys: new entry goes behind them
                        while (dst < count && !(k < keys[dst])) dst++;
                        place(dst, k, it.tag);
                    end
                end
                spq_pkg::FUNC_EXTRACT: begin
                    if (count == 0) begin
                        r.status = spq_pkg::ST_EMPTY;
                    end else begin
                        r.out_tag      = tags[0];
                        r.out_priority = keys[0];
                        drop(0);
                    end
                end
                default: begin
                    for (int j = 0; j < count && hit < 0; j++)
                        if (tags[j] == it.tag) hit = j;
                    if (hit < 0) begin
                        r.status = spq_pkg::ST_NOT_FOUND;
                    end else begin
                        drop(hit);
                        if (it.func == spq_pkg::FUNC_CHANGE) begin
                            lo = 0;
                            hi = 0;
                            for (int j = 0; j < count; j++) begin
                                if (keys[j] < k) lo++;
                                if (!(k < keys[j])) hi++;
                            end
                            // stay put if already within the run of equal keys
                            dst = hit;
                            if (dst < lo) dst = lo;
                            if (dst > hi) dst = hi;
                            place(dst, k, it.tag);
                        end
                    end
                end
            endcase
            r.occupancy = count[4:0];
            awaited.push_back(r);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(spq_pkg::t_out_item got);
            spq_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: unexpected item, expected none, actual %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got.out_tag !== want.out_tag)
                flag("out_tag", 32'(want.out_tag), 32'(got.out_tag));
            if (got.out_priority !== want.out_priority)
                flag("out_priority", want.out_priority, got.out_priority);
            if (got.status !== want.status)
                flag("status", 32'(want.status), 32'(got.status));
            if (got.occupancy !== want.occupancy)
                flag("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    spq_pkg::t_in_item  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b1;
    spq_pkg::t_out_item o_out;

    sorted_queue_ledger ledger = new();
    bit  in_calm  = 1'b0;
    bit  out_calm = 1'b0;
    int  cycles   = 0;

    sorted_priority_queue #(
        .CAPACITY  (DEPTH),
        .TAG_WIDTH (TAGW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(input spq_pkg::t_in_item it);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_op(it);
    endtask

    task automatic push_op(input spq_pkg::t_func f, input logic [15:0] t,
                           input logic signed [31:0] k);
        spq_pkg::t_in_item it;
        it.func         = f;
        it.tag          = t;
        it.priority_req = k;
        send_item(it);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.awaited.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_key();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        n    = ledger.count;
        if (roll < 40 && n > 0)
            return ledger.keys[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
        if (roll < 55) begin
            unique case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        if (roll < 70)
            return ($urandom_range(0, 7) - 4) * 65536;
        return $urandom;
    endfunction

    task automatic send_random(input int bias);
        spq_pkg::t_in_item it;
        int                roll;
        int                n;
        roll = $urandom_range(0, 99);
        n    = ledger.count;
        unique case (bias)
            0:       it.func = roll < 55 ? spq_pkg::FUNC_INSERT :
                               roll < 70 ? spq_pkg::FUNC_EXTRACT :
                               roll < 88 ? spq_pkg::FUNC_CHANGE : spq_pkg::FUNC_REMOVE;
            1:       it.func = roll < 20 ? spq_pkg::FUNC_INSERT :
                               roll < 60 ? spq_pkg::FUNC_EXTRACT :
                               roll < 80 ? spq_pkg::FUNC_CHANGE : spq_pkg::FUNC_REMOVE;
            default: it.func = roll < 35 ? spq_pkg::FUNC_INSERT :
                               roll < 55 ? spq_pkg::FUNC_EXTRACT :
                               roll < 80 ? spq_pkg::FUNC_CHANGE : spq_pkg::FUNC_REMOVE;
        endcase
        it.tag          = 16'($urandom);
        it.priority_req = pick_key();
        // mostly aim change/remove at live tags, inserts sometimes reuse one
        if (n > 0 && $urandom_range(0, 9) < 8 &&
                (it.func == spq_pkg::FUNC_CHANGE || it.func == spq_pkg::FUNC_REMOVE ||
                 (it.func == spq_pkg::FUNC_INSERT && $urandom_range(0, 9) < 3)))
            it.tag = ledger.tags[$urandom_range(0, n - 1)];
        // noise
        if ($urandom_range(0, 9) == 0) begin
            it.func         = spq_pkg::t_func'($urandom_range(0, 3));
            it.tag          = 16'($urandom);
            it.priority_req = $urandom;
        end
        send_item(it);
    endtask

    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = out_calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            ledger.check_result(o_out);
        end
    end

    initial begin
        int mode;
        int bias;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue cases
        push_op(spq_pkg::FUNC_EXTRACT, 16'h0000, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_CHANGE,  16'h1234, 32'sh0001_0000);
        push_op(spq_pkg::FUNC_REMOVE,  16'hffff, 32'sh7fff_ffff);
        // fill to capacity, extremes, equal keys, duplicate tags
        push_op(spq_pkg::FUNC_INSERT, 16'hffff, 32'sh7fff_ffff);
        push_op(spq_pkg::FUNC_INSERT, 16'h0000, 32'sh8000_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0001, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0002, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0003, 32'sh0001_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0004, -32'sh0001_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0005, 32'sh0001_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'h0001, 32'sh0002_0000);
        for (int j = 0; j < 8; j++)
            push_op(spq_pkg::FUNC_INSERT, 16'(16'h5a10 + j),
                    j * 32'sh0000_8000 - 32'sh0002_0000);
        push_op(spq_pkg::FUNC_INSERT, 16'haaaa, 32'sh0000_0005);
        // moves toward tail, toward head, no move
        push_op(spq_pkg::FUNC_CHANGE, 16'h0001, 32'sh0001_0000);
        push_op(spq_pkg::FUNC_CHANGE, 16'hffff, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_CHANGE, 16'h0002, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_REMOVE, 16'h0001, 32'sh0000_0000);
        push_op(spq_pkg::FUNC_EXTRACT, 16'h0000, 32'sh0000_0000);
        drain();

        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            bias     = $urandom_range(0, 2);
            mode     = $urandom_range(0, 3);
            in_calm  = (mode == 1 || mode == 3);
            out_calm = (mode >= 2);
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_random(bias);
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        in_calm  = 1'b0;
        out_calm = 1'b0;
        drain();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
